FILE: hdl/ebb_pkg.sv
// ebb_pkg: shared types and constants for the edge normalized box blur core
// pixel type, configuration register indexes and their reset values
// no dependencies
package ebb_pkg;

    localparam int CH_W = 16;
    localparam int N_CH = 3;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef logic [N_CH-1:0][CH_W-1:0] pix_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FWIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FHEIGHT = 2'd2;

    localparam logic [3:0]  RADIUS_RST  = 4'd2;
    localparam logic [11:0] FWIDTH_RST  = 12'd640;
    localparam logic [12:0] FHEIGHT_RST = 13'd480;

endpackage

FILE: hdl/ebb_ram.sv
// ebb_ram: generic single write port, single read port ram with registered read
// no dependencies
module ebb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 36864
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/ebb_div_cell.sv
// ebb_div_cell: one restoring division step for all three channels
// forms one quotient bit and hands remainder and dividend to the next cell
// depends on ebb_pkg
module ebb_div_cell
    import ebb_pkg::*;
#(
    parameter int CNT_W = 9
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        vld_i,
    input  logic [CNT_W-1:0]            cnt_i,
    input  logic [N_CH-1:0][CNT_W-1:0]  rem_i,
    input  pix_t                        dvd_i,
    input  pix_t                        quo_i,
    output logic                        vld_o,
    output logic [CNT_W-1:0]            cnt_o,
    output logic [N_CH-1:0][CNT_W-1:0]  rem_o,
    output pix_t                        dvd_o,
    output pix_t                        quo_o
);

    logic                        vld_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [N_CH-1:0][CNT_W-1:0]  rem_reg, rem_next;
    pix_t                        dvd_reg, dvd_next;
    pix_t                        quo_reg, quo_next;
    logic [CNT_W:0]              trial [N_CH];
    logic [N_CH-1:0]             ge;

    always_comb
    begin
        for (int ch = 0; ch < N_CH; ch++)
        begin
            trial[ch] = {rem_i[ch], dvd_i[ch][CH_W-1]};
            ge[ch]    = trial[ch] >= {1'b0, cnt_i};
            rem_next[ch] = ge[ch] ? CNT_W'(trial[ch] - {1'b0, cnt_i}) : CNT_W'(trial[ch]);
            dvd_next[ch] = {dvd_i[ch][CH_W-2:0], 1'b0};
            quo_next[ch] = {quo_i[ch][CH_W-2:0], ge[ch]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_i;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_i;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    assign vld_o = vld_reg;
    assign cnt_o = cnt_reg;
    assign rem_o = rem_reg;
    assign dvd_o = dvd_reg;
    assign quo_o = quo_reg;

endmodule

FILE: hdl/edge_normalized_box_blur_core.sv
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  kind, in_red, in_green, in_blue
// out       output     out_valid / out_stall out_red, out_green, out_blue, frame_last
// cfg       input      cfg_wr_en            cfg_index, cfg_data
//
// one transaction at a time: an item that gives no result goes from S_CHECK back to S_IDLE
// an item with a result reads the line store once per in-frame window pixel in S_SUM,
// then passes S_DRAIN, S_LAUNCH and the 16 cell division chain in S_WAIT, and holds
// in S_OUT while out_stall is high
// reset is asynchronous and active low; no clearing pass, the line store needs none
// in_stall is high from the cycle after an accepted transaction until its result is taken or S_CHECK finds none
//
// edge_normalized_box_blur_core: top level, control, line store and division chain
// depends on ebb_pkg, ebb_ram, ebb_div_cell
module edge_normalized_box_blur_core
    import ebb_pkg::*;
#(
    parameter int MAX_RADIUS = 8,
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  kind,
    input  logic [CH_W-1:0]       in_red,
    input  logic [CH_W-1:0]       in_green,
    input  logic [CH_W-1:0]       in_blue,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CH_W-1:0]       out_red,
    output logic [CH_W-1:0]       out_green,
    output logic [CH_W-1:0]       out_blue,
    output logic                  frame_last
);

    localparam int RING  = 2 * MAX_RADIUS + 2;
    localparam int SLW   = $clog2(RING);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int CW1   = CW + 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int RW1   = RW + 1;
    localparam int RADW  = $clog2(MAX_RADIUS + 1);
    localparam int SPW   = $clog2(2 * MAX_RADIUS + 2);
    localparam int WIN   = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int CNTW  = $clog2(WIN + 1);
    localparam int SW    = CH_W + CNTW;
    localparam int AW    = SLW + CW;
    localparam int DEPTH = RING * (2 ** CW);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CHECK  = 7'b0000010,
        S_SUM    = 7'b0000100,
        S_DRAIN  = 7'b0001000,
        S_LAUNCH = 7'b0010000,
        S_WAIT   = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [3:0]  radius_reg;
    logic [11:0] fwidth_reg;
    logic [12:0] fheight_reg;

    logic [RADW-1:0] r_eff;
    logic [WW-1:0]   w_eff;
    logic [RW-1:0]   h_eff;
    logic [CW-1:0]   w_last;
    logic [RW-1:0]   h_last;

    logic [CW-1:0]  in_col_reg, in_col_next;
    logic [RW-1:0]  in_row_reg, in_row_next;
    logic [SLW-1:0] in_slot_reg, in_slot_next;
    logic [CW-1:0]  out_col_reg, out_col_next;
    logic [RW-1:0]  out_row_reg, out_row_next;
    logic [SLW-1:0] out_slot_reg, out_slot_next;

    logic [RW-1:0]   rd_row_reg, rd_row_next, r1_reg, r1_next;
    logic [CW-1:0]   rd_col_reg, rd_col_next, c0_reg, c0_next, c1_reg, c1_next;
    logic [SLW-1:0]  rd_slot_reg, rd_slot_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            last_reg, last_next;
    logic            rd_vld_reg, rd_vld_next;
    logic [SW-1:0]   acc_reg [N_CH];
    logic [SW-1:0]   acc_next [N_CH];
    pix_t            out_pix_reg, out_pix_next;

    logic in_acc, pix_we, cfg_hit, ram_re;
    pix_t in_pix, rd_pix;

    logic [RW1-1:0]   row_plus;
    logic [CW1-1:0]   col_plus;
    logic [RW-1:0]    need_row, r0;
    logic [CW-1:0]    need_col, c0;
    logic             res_ready, is_last;
    logic [SPW-1:0]   row_span, col_span;
    logic [2*SPW-1:0] cnt_full;
    logic [RADW-1:0]  d_back;
    logic [SLW-1:0]   slot0;

    logic                       vld_c [CH_W+1];
    logic [CNTW-1:0]            cnt_c [CH_W+1];
    logic [N_CH-1:0][CNTW-1:0]  rem_c [CH_W+1];
    pix_t                       dvd_c [CH_W+1];
    pix_t                       quo_c [CH_W+1];

    // effective register values
    assign r_eff = (32'(radius_reg) > MAX_RADIUS) ? RADW'(MAX_RADIUS) : RADW'(radius_reg);
    assign w_eff = (fwidth_reg == '0) ? WW'(1) :
                   (32'(fwidth_reg) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(fwidth_reg);
    assign h_eff = (fheight_reg == '0) ? RW'(1) :
                   (32'(fheight_reg) > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(fheight_reg);
    assign w_last = CW'(w_eff - WW'(1));
    assign h_last = h_eff - RW'(1);

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign in_acc    = in_valid && !in_stall;
    assign pix_we    = in_acc && !kind && (in_row_reg < h_eff);
    assign cfg_hit   = cfg_wr_en && ((cfg_index == REG_RADIUS) || (cfg_index == REG_FWIDTH)
                       || (cfg_index == REG_FHEIGHT));
    assign ram_re    = (state_reg == S_SUM);

    always_comb
    begin
        in_pix = '0;
        in_pix[CH_RED]   = in_red;
        in_pix[CH_GREEN] = in_green;
        in_pix[CH_BLUE]  = in_blue;
    end

    // window bounds for the next output position
    always_comb
    begin
        row_plus  = {1'b0, out_row_reg} + RW1'(r_eff);
        col_plus  = {1'b0, out_col_reg} + CW1'(r_eff);
        need_row  = (row_plus > {1'b0, h_last}) ? h_last : row_plus[RW-1:0];
        need_col  = (col_plus > {1'b0, w_last}) ? w_last : col_plus[CW-1:0];
        res_ready = (out_row_reg <= h_last) && ((in_row_reg > need_row)
                    || ((in_row_reg == need_row) && (in_col_reg > need_col)));
        r0        = (out_row_reg >= RW'(r_eff)) ? out_row_reg - RW'(r_eff) : '0;
        c0        = (out_col_reg >= CW'(r_eff)) ? out_col_reg - CW'(r_eff) : '0;
        row_span  = SPW'(need_row - r0) + SPW'(1);
        col_span  = SPW'(need_col - c0) + SPW'(1);
        cnt_full  = row_span * col_span;
        d_back    = RADW'(out_row_reg - r0);
        slot0     = (out_slot_reg >= SLW'(d_back)) ? out_slot_reg - SLW'(d_back)
                    : out_slot_reg + SLW'(RING) - SLW'(d_back);
        is_last   = (out_col_reg == w_last) && (out_row_reg == h_last);
    end

    always_comb
    begin
        state_next    = state_reg;
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_slot_next  = in_slot_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_slot_next = out_slot_reg;
        rd_row_next   = rd_row_reg;
        rd_col_next   = rd_col_reg;
        rd_slot_next  = rd_slot_reg;
        r1_next       = r1_reg;
        c0_next       = c0_reg;
        c1_next       = c1_reg;
        cnt_next      = cnt_reg;
        last_next     = last_reg;
        rd_vld_next   = 1'b0;
        out_pix_next  = out_pix_reg;
        for (int ch = 0; ch < N_CH; ch++)
        begin
            acc_next[ch] = rd_vld_reg ? acc_reg[ch] + SW'(rd_pix[ch]) : acc_reg[ch];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (pix_we)
                    begin
                        if (in_col_reg == w_last)
                        begin
                            in_col_next  = '0;
                            in_row_next  = in_row_reg + RW'(1);
                            in_slot_next = (in_slot_reg == SLW'(RING - 1)) ? '0
                                           : in_slot_reg + SLW'(1);
                        end
                        else
                        begin
                            in_col_next = in_col_reg + CW'(1);
                        end
                    end
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (res_ready)
                begin
                    r1_next      = need_row;
                    c0_next      = c0;
                    c1_next      = need_col;
                    rd_row_next  = r0;
                    rd_col_next  = c0;
                    rd_slot_next = slot0;
                    cnt_next     = CNTW'(cnt_full);
                    last_next    = is_last;
                    for (int ch = 0; ch < N_CH; ch++)
                    begin
                        acc_next[ch] = '0;
                    end
                    if (out_col_reg == w_last)
                    begin
                        out_col_next  = '0;
                        out_row_next  = out_row_reg + RW'(1);
                        out_slot_next = (out_slot_reg == SLW'(RING - 1)) ? '0
                                        : out_slot_reg + SLW'(1);
                    end
                    else
                    begin
                        out_col_next = out_col_reg + CW'(1);
                    end
                    if (is_last)
                    begin
                        in_col_next   = '0;
                        in_row_next   = '0;
                        in_slot_next  = '0;
                        out_col_next  = '0;
                        out_row_next  = '0;
                        out_slot_next = '0;
                    end
                    state_next = S_SUM;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SUM:
            begin
                rd_vld_next = 1'b1;
                if (rd_col_reg == c1_reg)
                begin
                    rd_col_next = c0_reg;
                    if (rd_row_reg == r1_reg)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        rd_row_next  = rd_row_reg + RW'(1);
                        rd_slot_next = (rd_slot_reg == SLW'(RING - 1)) ? '0
                                       : rd_slot_reg + SLW'(1);
                    end
                end
                else
                begin
                    rd_col_next = rd_col_reg + CW'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_LAUNCH;
            end
            S_LAUNCH:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (vld_c[CH_W])
                begin
                    out_pix_next = quo_c[CH_W];
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register write abandons the frame in progress
        if (cfg_hit)
        begin
            in_col_next   = '0;
            in_row_next   = '0;
            in_slot_next  = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            out_slot_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_slot_reg  <= in_slot_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_slot_reg <= out_slot_next;
            rd_vld_reg   <= rd_vld_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= RADIUS_RST;
            fwidth_reg  <= FWIDTH_RST;
            fheight_reg <= FHEIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_RADIUS:  radius_reg  <= cfg_data[3:0];
                REG_FWIDTH:  fwidth_reg  <= cfg_data[11:0];
                REG_FHEIGHT: fheight_reg <= cfg_data[12:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rd_row_reg  <= rd_row_next;
        rd_col_reg  <= rd_col_next;
        rd_slot_reg <= rd_slot_next;
        r1_reg      <= r1_next;
        c0_reg      <= c0_next;
        c1_reg      <= c1_next;
        cnt_reg     <= cnt_next;
        last_reg    <= last_next;
        out_pix_reg <= out_pix_next;
        for (int ch = 0; ch < N_CH; ch++)
        begin
            acc_reg[ch] <= acc_next[ch];
        end
    end

    ebb_ram #(
        .WIDTH ($bits(pix_t)),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (pix_we),
        .waddr (AW'({in_slot_reg, in_col_reg})),
        .wdata (in_pix),
        .re    (ram_re),
        .raddr (AW'({rd_slot_reg, rd_col_reg})),
        .rdata (rd_pix)
    );

    // division chain head: remainder starts at the high part of the sum
    always_comb
    begin
        vld_c[0] = (state_reg == S_LAUNCH);
        cnt_c[0] = cnt_reg;
        rem_c[0] = '0;
        dvd_c[0] = '0;
        quo_c[0] = '0;
        for (int ch = 0; ch < N_CH; ch++)
        begin
            rem_c[0][ch] = acc_reg[ch][SW-1:CH_W];
            dvd_c[0][ch] = acc_reg[ch][CH_W-1:0];
        end
    end

    for (genvar i = 0; i < CH_W; i++)
    begin : g_div
        ebb_div_cell #(
            .CNT_W (CNTW)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .vld_i (vld_c[i]),
            .cnt_i (cnt_c[i]),
            .rem_i (rem_c[i]),
            .dvd_i (dvd_c[i]),
            .quo_i (quo_c[i]),
            .vld_o (vld_c[i+1]),
            .cnt_o (cnt_c[i+1]),
            .rem_o (rem_c[i+1]),
            .dvd_o (dvd_c[i+1]),
            .quo_o (quo_c[i+1])
        );
    end

    assign out_red    = out_pix_reg[CH_RED];
    assign out_green  = out_pix_reg[CH_GREEN];
    assign out_blue   = out_pix_reg[CH_BLUE];
    assign frame_last = last_reg;

    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while a result waits");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pix_we |-> (state_reg == S_IDLE))
        else $error("line store written outside idle");

    a_chain_wait: assert property (@(posedge clk) disable iff (!rst_n)
        vld_c[CH_W] |-> (state_reg == S_WAIT))
        else $error("quotient left the chain outside wait");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LAUNCH) |-> (cnt_reg != '0))
        else $error("division by a zero window count");

    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> (state_reg == S_IDLE))
        else $error("no return to idle after output transaction");

endmodule

FILE: test/testbench.sv
// testbench: self-checking bench for edge_normalized_box_blur_core
// runs a directed table and then random frames, and checks every result transaction
// depends on ebb_pkg and edge_normalized_box_blur_core
`timescale 1ns / 100ps

module testbench;
    import ebb_pkg::*;

    localparam int RING = 18;
    localparam int MAXW = 2048;
    localparam int MAXH = 4096;
    localparam int LIMIT = 20000;
    localparam int TARGET = 1750;

    // index past the register list
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    typedef enum logic [1:0] {OP_PIX, OP_FLUSH, OP_CFG} row_op_t;

    typedef struct {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            last;
    } blur_res_t;

    typedef struct {
        row_op_t               op;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [CH_W-1:0]       red;
        logic [CH_W-1:0]       green;
        logic [CH_W-1:0]       blue;
        bit                    typed;
        blur_res_t             res;
    } stim_row_t;

    logic clk, rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid, in_stall, kind;
    logic [CH_W-1:0] in_red, in_green, in_blue;
    logic out_valid, out_stall;
    logic [CH_W-1:0] out_red, out_green, out_blue;
    logic frame_last;

    edge_normalized_box_blur_core dut (.*);

    // predictor state
    logic [CH_W-1:0] pix_store [RING*MAXW][3];
    int unsigned in_col, in_row, out_col, out_row;
    logic [3:0] radius_q;
    logic [11:0] width_q;
    logic [12:0] height_q;
    bit frame_done;

    blur_res_t mean_q[$];
    int errors = 0;
    int n_items = 0;
    bit idle_on = 1;
    int stall_left = 0;
    int quiet_cycles = 0;
    stim_row_t dir_rows[26];

    function automatic void restart_frame();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function automatic void blur_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        if (idx == REG_RADIUS) radius_q = d[3:0];
        else if (idx == REG_FWIDTH) width_q = d[11:0];
        else if (idx == REG_FHEIGHT) height_q = d;
        else return;
        restart_frame();
    endfunction

    function automatic bit blur_step(logic k, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                     logic [CH_W-1:0] b, output blur_res_t res);
        int unsigned w, h, rd, nrow, ncol, r0, c0, cnt, slot_idx;
        longint unsigned s0, s1, s2;
        w = (width_q == 0) ? 1 : (width_q > MAXW ? MAXW : width_q);
        h = (height_q == 0) ? 1 : (height_q > MAXH ? MAXH : height_q);
        rd = (radius_q > 8) ? 8 : radius_q;
        res = '{default: '0};
        if (in_col >= w) in_col = 0;
        if (out_col >= w) out_col = 0;
        if (k == 1'b0 && in_row < h) begin
            slot_idx = (in_row % RING) * MAXW + in_col;
            pix_store[slot_idx][0] = r;
            pix_store[slot_idx][1] = g;
            pix_store[slot_idx][2] = b;
            if (++in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end
        if (out_row >= h) return 0;
        nrow = (out_row + rd > h - 1) ? h - 1 : out_row + rd;
        ncol = (out_col + rd > w - 1) ? w - 1 : out_col + rd;
        if (!(in_row > nrow || (in_row == nrow && in_col > ncol))) return 0;
        r0 = (out_row >= rd) ? out_row - rd : 0;
        c0 = (out_col >= rd) ? out_col - rd : 0;
        s0 = 0;
        s1 = 0;
        s2 = 0;
        for (int unsigned y = r0; y <= nrow; y++)
            for (int unsigned x = c0; x <= ncol; x++)
            begin
                slot_idx = (y % RING) * MAXW + x;
                s0 += pix_store[slot_idx][0];
                s1 += pix_store[slot_idx][1];
                s2 += pix_store[slot_idx][2];
            end
        cnt = (nrow - r0 + 1) * (ncol - c0 + 1);
        res.red = CH_W'(s0 / cnt);
        res.green = CH_W'(s1 / cnt);
        res.blue = CH_W'(s2 / cnt);
        if (++out_col >= w) begin
            out_col = 0;
            out_row++;
        end
        if (out_row >= h) begin
            res.last = 1'b1;
            frame_done = 1;
            restart_frame();
        end
        return 1;
    endfunction

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // result checking and watchdog
    always @(negedge clk)
    begin
        blur_res_t e;
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
        if (rst_n && out_valid && !out_stall) begin
            if (mean_q.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
            end else begin
                e = mean_q.pop_front();
                if (out_red !== e.red) begin
                    $error("out_red expected %h actual %h", e.red, out_red);
                    errors++;
                end
                if (out_green !== e.green) begin
                    $error("out_green expected %h actual %h", e.green, out_green);
                    errors++;
                end
                if (out_blue !== e.blue) begin
                    $error("out_blue expected %h actual %h", e.blue, out_blue);
                    errors++;
                end
                if (frame_last !== e.last) begin
                    $error("frame_last expected %b actual %b", e.last, frame_last);
                    errors++;
                end
            end
        end
    end

    // receiver stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0) stall_left--;
        else if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 9);
        out_stall <= (stall_left > 0);
    end

    task automatic send_item(logic k, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                             logic [CH_W-1:0] b, bit typed, blur_res_t te);
        blur_res_t res;
        bit got, stl;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        in_red <= r;
        in_green <= g;
        in_blue <= b;
        do begin
            @(negedge clk);
            stl = in_stall;
            @(posedge clk);
        end while (stl);
        got = blur_step(k, r, g, b, res);
        if (got || typed) mean_q.push_back(typed ? te : res);
        n_items++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (mean_q.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        blur_config(idx, d);
    endtask

    function automatic logic [CH_W-1:0] rand_ch();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return CH_W'($urandom);
        endcase
    endfunction

    task automatic send_rand(logic k);
        send_item(k, rand_ch(), rand_ch(), rand_ch(), 0, '{default: '0});
    endtask

    initial
    begin
        blur_res_t none;
        int w, h, rd, npix;
        none = '{default: '0};
        rst_n = 0;
        cfg_wr_en = 0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 0;
        kind = 0;
        in_red = '0;
        in_green = '0;
        in_blue = '0;
        out_stall = 0;
        radius_q = RADIUS_RST;
        width_q = FWIDTH_RST;
        height_q = FHEIGHT_RST;
        restart_frame();

        dir_rows = '{
            '{OP_CFG, REG_RADIUS, 13'd0, 16'h0, 16'h0, 16'h0, 0, none},
            '{OP_CFG, REG_FWIDTH, 13'd2, 16'h0, 16'h0, 16'h0, 0, none},
            '{OP_CFG, REG_FHEIGHT, 13'd2, 16'h0, 16'h0, 16'h0, 0, none},
            '{OP_PIX, '0, '0, 16'hffff, 16'h0000, 16'h0001, 1,
              '{16'hffff, 16'h0000, 16'h0001, 1'b0}},
            '{OP_PIX, '0, '0, 16'h0000, 16'hffff, 16'h8000, 1,
              '{16'h0000, 16'hffff, 16'h8000, 1'b0}},
            '{OP_FLUSH, '0, '0, 16'hffff, 16'hffff, 16'hffff, 0, none},
            '{OP_PIX, '0, '0, 16'h00ff, 16'hff00, 16'h5555, 1,
              '{16'h00ff, 16'hff00, 16'h5555, 1'b0}},
            '{OP_PIX, '0, '0, 16'h1234, 16'habcd, 16'h0000, 1,
              '{16'h1234, 16'habcd, 16'h0000, 1'b1}},
            '{OP_FLUSH, '0, '0, 16'h0, 16'h0, 16'h0, 0, none},
            '{OP_CFG, REG_RADIUS, 13'd1, 16'h0, 16'h0, 16'h0, 0, none},
            '{OP_CFG, REG_FWIDTH, 13'd3, 16'h0, 16'h0, 16'h0, 0, none},
            '{OP_PIX, '0, '0, 16'hffff, 16'hffff, 16'hffff, 0, none},
            '{OP_FLUSH, '0, '0, 16'h0, 16'h0, 16'h0, 0, none},
            '{OP_PIX, '0, '0, 16'hffff, 16'h0001, 16'h0000, 0, none},
            '{OP_PIX, '0, '0, 16'h0000, 16'h0002, 16'hffff, 0, none},
            '{OP_PIX, '0, '0, 16'h8000, 16'h0003, 16'h7fff, 0, none},
            '{OP_PIX, '0, '0, 16'hffff, 16'h0004, 16'hffff, 0, none},
            '{OP_PIX, '0, '0, 16'h0001, 16'hffff, 16'hffff, 0, none},
            '{OP_PIX, '0, '0, 16'hffff, 16'hffff, 16'h0000, 0, none},
            '{OP_PIX, '0, '0, 16'hdead, 16'hbeef, 16'hcafe, 0, none},
            '{OP_FLUSH, '0, '0, 16'h0, 16'h0, 16'h0, 0, none},
            '{OP_FLUSH, '0, '0, 16'h0, 16'h0, 16'h0, 0, none},
            '{OP_FLUSH, '0, '0, 16'h0, 16'h0, 16'h0, 0, none},
            '{OP_CFG, REG_RADIUS, 13'd15, 16'h0, 16'h0, 16'h0, 0, none},
            '{OP_CFG, REG_FWIDTH, 13'd0, 16'h0, 16'h0, 16'h0, 0, none},
            '{OP_CFG, REG_FHEIGHT, 13'd0, 16'h0, 16'h0, 16'h0, 0, none}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].op == OP_CFG) cfg_write(dir_rows[i].idx, dir_rows[i].data);
            else send_item(dir_rows[i].op == OP_FLUSH, dir_rows[i].red, dir_rows[i].green,
                           dir_rows[i].blue, dir_rows[i].typed, dir_rows[i].res);
        end
        // one pixel frame with the widest radius
        send_item(1'b0, 16'h4321, 16'hffff, 16'h0000, 1, '{16'h4321, 16'hffff, 16'h0000, 1'b1});
        cfg_write(REG_NONE, 13'h1fff);

        while (n_items < TARGET)
        begin
            idle_on = (n_items < TARGET - 250);
            case ($urandom_range(0, 9))
                0: begin
                    // large or oversized frame, abandoned part way
                    if ($urandom_range(0, 1)) begin
                        w = $urandom_range(0, 1) ? 4095 : 2048;
                        h = $urandom_range(1, 3);
                    end else begin
                        w = $urandom_range(1, 2);
                        h = $urandom_range(0, 1) ? 8191 : 4096;
                    end
                    rd = $urandom_range(0, 15);
                end
                1: begin
                    w = $urandom_range(0, 3);
                    h = $urandom_range(0, 3);
                    rd = $urandom_range(0, 1) ? 15 : 0;
                end
                default: begin
                    w = $urandom_range(1, 12);
                    h = $urandom_range(1, 8);
                    rd = $urandom_range(0, 9);
                end
            endcase
            cfg_write(REG_RADIUS, CFG_DATA_W'(rd));
            cfg_write(REG_FWIDTH, CFG_DATA_W'(w));
            cfg_write(REG_FHEIGHT, CFG_DATA_W'(h));
            if ($urandom_range(0, 7) == 0) cfg_write(REG_NONE, CFG_DATA_W'($urandom));
            if (w * h > 300) begin
                npix = $urandom_range(20, 150);
                repeat (npix)
                begin
                    if ($urandom_range(0, 9) == 0) send_rand(1'b1);
                    send_rand(1'b0);
                end
            end else begin
                repeat ($urandom_range(1, 3))
                begin
                    frame_done = 0;
                    npix = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
                    for (int p = 0; p < npix; p++)
                    begin
                        if ($urandom_range(0, 9) == 0) send_rand(1'b1);
                        send_rand(1'b0);
                    end
                    if ($urandom_range(0, 2) == 0 && !frame_done) send_rand(1'b0);
                    while (!frame_done) send_rand($urandom_range(0, 3) != 0);
                end
            end
        end

        idle_on = 0;
        wait_idle();
        repeat (400) @(posedge clk);
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule

FILE: files.f
hdl/ebb_pkg.sv
hdl/ebb_ram.sv
hdl/ebb_div_cell.sv
hdl/edge_normalized_box_blur_core.sv
test/testbench.sv
